@@ rtl/core/rss_pkg.sv @@
`default_nettype none

package rss_pkg;

	localparam int unsigned RANGE_W = 16;
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned STEP_W = 13;
	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	localparam int unsigned MAX_SAMPLES_DEF = 4096;
	localparam int unsigned JOB_QUEUE_DEPTH = 4;

	localparam logic signed [ANGLE_W-1:0] FIRST_ANGLE_RST = -16'sd31416;
	localparam logic [STEP_W-1:0] ANGLE_STEP_RST = 13'd63;
	localparam logic [RANGE_W-1:0] GAP_LIMIT_RST = 16'd65535;
	localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST = 16'd2072;

	typedef enum logic [1:0] {
		REG_FIRST_ANGLE = 2'd0,
		REG_ANGLE_STEP  = 2'd1,
		REG_GAP_LIMIT   = 2'd2,
		REG_NEAR_LIMIT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range_mm;
		logic               range_ok;
		logic               scan_end;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] seg_start_angle;
		logic signed [ANGLE_W-1:0] seg_end_angle;
		logic [RANGE_W-1:0]        seg_mean_range;
	} seg_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] first_angle;
		logic [STEP_W-1:0]         angle_step;
		logic [RANGE_W-1:0]        gap_limit;
		logic [RANGE_W-1:0]        near_limit;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/rss_front.sv @@
`default_nettype none

module rss_front #(
	parameter int unsigned MAX_SAMPLES = rss_pkg::MAX_SAMPLES_DEF,
	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1),
	localparam int unsigned SUM_W = rss_pkg::RANGE_W + $clog2(MAX_SAMPLES)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rss_pkg::cfg_t             cfg,
	input  wire logic                      sample_valid,
	output logic                           sample_ready,
	input  wire rss_pkg::sample_t          sample,
	input  wire logic                      job_full,
	output logic                           job_push,
	output logic [rss_pkg::ANGLE_W-1:0]    job_start,
	output logic [rss_pkg::ANGLE_W-1:0]    job_end,
	output logic [SUM_W-1:0]               job_sum,
	output logic [CNT_W-1:0]               job_cnt
);
	import rss_pkg::*;

	logic [RANGE_W-1:0] held_range_q;
	logic [ANGLE_W-1:0] held_angle_q;
	logic               have_held_q;
	logic [ANGLE_W-1:0] run_start_q;
	logic [SUM_W-1:0]   run_sum_q;
	logic [CNT_W-1:0]   run_cnt_q;

	logic [RANGE_W-1:0] cur_range;
	logic [RANGE_W-1:0] diff;
	logic               extend;
	logic               close;
	logic               room;
	logic               accept;

	always_comb begin
		cur_range = sample.range_ok ? sample.range_mm : '0;
		diff = (held_range_q >= cur_range) ? (held_range_q - cur_range)
			: (cur_range - held_range_q);
		extend = have_held_q && (held_range_q != '0) && (diff <= cfg.gap_limit);
		close = have_held_q && !extend && (run_cnt_q != '0);
		room = run_cnt_q < CNT_W'(MAX_SAMPLES - 1);
	end

	assign sample_ready = !job_full;
	assign accept = sample_valid && sample_ready;

	// The held sample joins the closing run as its last member.
	assign job_push = accept && close;
	assign job_start = run_start_q;
	assign job_end = held_angle_q;
	assign job_sum = run_sum_q + SUM_W'(held_range_q);
	assign job_cnt = run_cnt_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_range_q <= '0;
			held_angle_q <= '0;
			have_held_q <= 1'b0;
			run_start_q <= '0;
			run_sum_q <= '0;
			run_cnt_q <= '0;
		end else if (accept) begin
			if (sample.scan_end) begin
				held_range_q <= '0;
				held_angle_q <= '0;
				have_held_q <= 1'b0;
				run_start_q <= '0;
				run_sum_q <= '0;
				run_cnt_q <= '0;
			end else begin
				if (extend) begin
					if (run_cnt_q == '0) begin
						run_start_q <= held_angle_q;
					end
					if (room) begin
						run_sum_q <= run_sum_q + SUM_W'(held_range_q);
						run_cnt_q <= run_cnt_q + CNT_W'(1);
					end
				end else if (close) begin
					run_start_q <= '0;
					run_sum_q <= '0;
					run_cnt_q <= '0;
				end
				held_range_q <= cur_range;
				held_angle_q <= have_held_q
					? (held_angle_q + ANGLE_W'(cfg.angle_step))
					: cfg.first_angle;
				have_held_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rss_fifo.sv @@
`default_nettype none

module rss_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = rss_pkg::JOB_QUEUE_DEPTH,
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned FILL_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head,
	output logic                  full,
	output logic                  empty
);
	logic [WIDTH-1:0]  mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign full = (fill_q == FILL_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rss_back.sv @@
`default_nettype none

module rss_back #(
	parameter int unsigned MAX_SAMPLES = rss_pkg::MAX_SAMPLES_DEF,
	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1),
	localparam int unsigned SUM_W = rss_pkg::RANGE_W + $clog2(MAX_SAMPLES)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [rss_pkg::RANGE_W-1:0] near_limit,
	input  wire logic                      job_valid,
	output logic                           job_pop,
	input  wire logic [rss_pkg::ANGLE_W-1:0] job_start,
	input  wire logic [rss_pkg::ANGLE_W-1:0] job_end,
	input  wire logic [SUM_W-1:0]          job_sum,
	input  wire logic [CNT_W-1:0]          job_cnt,
	output logic                           seg_valid,
	input  wire logic                      seg_ready,
	output rss_pkg::seg_t                  seg
);
	import rss_pkg::*;

	localparam int unsigned STEP_CW = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_FIN
	} back_state_t;

	back_state_t          state_q;
	logic [STEP_CW-1:0]   step_q;
	logic [SUM_W-1:0]     dq_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ANGLE_W-1:0]   start_q;
	logic [ANGLE_W-1:0]   end_q;
	logic                 seg_valid_q;
	seg_t                 seg_q;

	logic [CNT_W:0]       trial;
	logic                 qbit;
	logic [CNT_W-1:0]     rem_nx;
	logic [RANGE_W-1:0]   quot;
	logic                 pass;
	logic                 load_seg;

	// One restoring step per cycle; quotient bits shift in behind the dividend.
	always_comb begin
		trial = {rem_q, dq_q[SUM_W-1]};
		qbit = (trial >= {1'b0, cnt_q});
		rem_nx = qbit ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
		quot = dq_q[RANGE_W-1:0];
		// The exact mean is within the limit when the truncated mean is below
		// it, or equals it with nothing left over.
		pass = (quot < near_limit) || ((quot == near_limit) && (rem_q == '0));
		load_seg = (state_q == B_FIN) && pass && (!seg_valid_q || seg_ready);
	end

	assign job_pop = (state_q == B_IDLE) && job_valid;
	assign seg_valid = seg_valid_q;
	assign seg = seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= '0;
			dq_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			start_q <= '0;
			end_q <= '0;
			seg_valid_q <= 1'b0;
			seg_q <= '0;
		end else begin
			if (load_seg) begin
				seg_valid_q <= 1'b1;
			end else if (seg_valid_q && seg_ready) begin
				seg_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						dq_q <= job_sum;
						cnt_q <= job_cnt;
						start_q <= job_start;
						end_q <= job_end;
						rem_q <= '0;
						step_q <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					rem_q <= rem_nx;
					dq_q <= {dq_q[SUM_W-2:0], qbit};
					step_q <= step_q + STEP_CW'(1);
					if (step_q == STEP_CW'(SUM_W - 1)) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					if (!pass) begin
						state_q <= B_IDLE;
					end else if (load_seg) begin
						seg_q.seg_start_angle <= start_q;
						seg_q.seg_end_angle <= end_q;
						seg_q.seg_mean_range <= quot;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/range_scan_segmenter.sv @@
`default_nettype none

// Channel   | Direction | Handshake                 | Payload
// sample    | in        | sample_valid/sample_ready | rss_pkg::sample_t
// seg       | out       | seg_valid/seg_ready       | rss_pkg::seg_t
// config    | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Samples are taken at one per cycle while the run queue has room; the front
// judges each held sample against its neighbor in the cycle of the transaction.
// Each closed run passes through the back end's load, bit-serial divide and
// finish steps, and the back end takes one run at a time.
// Reset is asynchronous, clears all scan state and restores the configuration defaults.
// A stalled result output holds the back end, which lets the queue fill, and
// only then is sample_ready dropped.

module range_scan_segmenter #(
	parameter int unsigned MAX_SAMPLES = rss_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_ready,
	input  wire rss_pkg::sample_t             sample,
	output logic                              seg_valid,
	input  wire logic                         seg_ready,
	output rss_pkg::seg_t                     seg,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rss_pkg::APB_AW-1:0]   paddr,
	input  wire logic [rss_pkg::APB_DW-1:0]   pwdata,
	output logic [rss_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);
	import rss_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SUM_W = RANGE_W + $clog2(MAX_SAMPLES);
	localparam int unsigned JOB_W = 2 * ANGLE_W + SUM_W + CNT_W;

	cfg_t               cfg_q;
	logic               cfg_wr;
	reg_idx_t           reg_idx;

	logic               job_push;
	logic [ANGLE_W-1:0] push_start;
	logic [ANGLE_W-1:0] push_end;
	logic [SUM_W-1:0]   push_sum;
	logic [CNT_W-1:0]   push_cnt;
	logic [JOB_W-1:0]   queue_head;
	logic               queue_full;
	logic               queue_empty;
	logic               job_pop;

	// The register file. Writes complete in the access phase; pready never
	// stretches a transaction.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_angle <= FIRST_ANGLE_RST;
			cfg_q.angle_step <= ANGLE_STEP_RST;
			cfg_q.gap_limit <= GAP_LIMIT_RST;
			cfg_q.near_limit <= NEAR_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FIRST_ANGLE: cfg_q.first_angle <= pwdata[ANGLE_W-1:0];
				REG_ANGLE_STEP:  cfg_q.angle_step <= pwdata[STEP_W-1:0];
				REG_GAP_LIMIT:   cfg_q.gap_limit <= pwdata[RANGE_W-1:0];
				REG_NEAR_LIMIT:  cfg_q.near_limit <= pwdata[RANGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Reads return the stored value; the signed angle reads back sign extended.
	always_comb begin
		case (reg_idx)
			REG_FIRST_ANGLE: prdata = APB_DW'(cfg_q.first_angle);
			REG_ANGLE_STEP:  prdata = APB_DW'(cfg_q.angle_step);
			REG_GAP_LIMIT:   prdata = APB_DW'(cfg_q.gap_limit);
			REG_NEAR_LIMIT:  prdata = APB_DW'(cfg_q.near_limit);
			default:         prdata = '0;
		endcase
	end

	// The front tracks the held sample and the open run, and hands every
	// closed run to the queue as a mean job.
	rss_front #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.job_full(queue_full),
		.job_push(job_push),
		.job_start(push_start),
		.job_end(push_end),
		.job_sum(push_sum),
		.job_cnt(push_cnt)
	);

	rss_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_data({push_start, push_end, push_sum, push_cnt}),
		.pop(job_pop),
		.head(queue_head),
		.full(queue_full),
		.empty(queue_empty)
	);

	// The back end divides the run sum by its count, applies the distance
	// test and registers a passing result for the output channel.
	rss_back #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.near_limit(cfg_q.near_limit),
		.job_valid(!queue_empty),
		.job_pop(job_pop),
		.job_start(queue_head[JOB_W-1 -: ANGLE_W]),
		.job_end(queue_head[JOB_W-ANGLE_W-1 -: ANGLE_W]),
		.job_sum(queue_head[SUM_W+CNT_W-1 -: SUM_W]),
		.job_cnt(queue_head[CNT_W-1:0]),
		.seg_valid(seg_valid),
		.seg_ready(seg_ready),
		.seg(seg)
	);

endmodule

`default_nettype wire

@@ rtl/core/rss_checker.sv @@
`default_nettype none

module rss_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             sample_valid,
	input wire logic             sample_ready,
	input wire logic             seg_valid,
	input wire logic             seg_ready,
	input wire rss_pkg::seg_t    seg,
	input wire logic             pready
);

	// A result waiting at the output keeps its value until taken.
	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(seg))
		else $error("segment output changed while stalled");

	// The run queue only fills through a sample transaction, so the input
	// can only start stalling right after one.
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ready) |-> $past(sample_valid && sample_ready))
		else $error("sample input stalled without a preceding transaction");

	// Reset leaves no result on the output.
	a_seg_reset: assert property (@(posedge clk)
		!arst_n |-> !seg_valid)
		else $error("segment valid during reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port stretched a transaction");

endmodule

bind range_scan_segmenter rss_checker u_rss_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample_valid),
	.sample_ready(sample_ready),
	.seg_valid(seg_valid),
	.seg_ready(seg_ready),
	.seg(seg),
	.pready(pready)
);

`default_nettype wire
